// ----- sv/wptd_pkg.sv -----
// Shared types and fixed widths for the window peak and trough detector.
package wptd_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned INDEX_W      = 32;
  localparam int unsigned RADIUS_CFG_W = 5;
  localparam int unsigned FX_W         = 2;

  // Result classification
  typedef enum logic [FX_W-1:0] {
    FX_NONE   = 2'd0,
    FX_TOP    = 2'd1,
    FX_BOTTOM = 2'd2
  } fx_type_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READV,
    ST_SCAN,
    ST_TAIL,
    ST_FILT
  } wptd_state_e;

endpackage

// ----- sv/window_peak_trough_detector_top.sv -----
// Each sample is stored in the window RAM; for each result the window distances 0 to hi are
// read, where hi = min(d+r, n-1) is the last window distance read. A normal sample yields at
// most one result, an end-of-series sample up to r+1 results. The single window RAM read
// port reads one sample per cycle. A new sample is taken once the last result of the previous
// one sits in the output register. Reset (async, active low) clears control, counters, filter
// state and radius (3); RAM not cleared.
module window_peak_trough_detector_top #(
  parameter int unsigned MAX_RADIUS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Radius register write
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [wptd_pkg::RADIUS_CFG_W-1:0]      cfg_window_radius_i,
  // Sample input
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [wptd_pkg::SAMPLE_W-1:0]   sample_value_i,
  input  logic                                   end_of_series_i,
  // Classified results
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [wptd_pkg::FX_W-1:0]              fx_type_o,
  output logic [wptd_pkg::INDEX_W-1:0]           sample_index_o,
  output logic signed [wptd_pkg::SAMPLE_W-1:0]   echo_value_o,
  output logic                                   last_of_run_o
);
  import wptd_pkg::*;

  localparam int unsigned DEPTH = 2 * MAX_RADIUS + 1;
  localparam int unsigned SW    = $clog2(DEPTH);
  localparam int unsigned DW    = SW;
  localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);

  // Ring slot holding the sample back_d positions behind base
  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
                                            input logic [DW-1:0] back_d);
    logic [SW:0] wrapped;
    wrapped = {1'b0, base} + (SW+1)'(DEPTH) - {1'b0, back_d};
    if (base >= back_d) return base - back_d;
    else return wrapped[SW-1:0];
  endfunction

  // Control state
  wptd_state_e              state_q, state_d;
  logic [RADIUS_CFG_W-1:0]  cfg_radius_q;
  logic [SW-1:0]            wr_slot_q, wr_slot_d;
  logic [INDEX_W-1:0]       count_q, count_d;
  fx_type_e                 kept_type_q, kept_type_d;
  logic signed [SAMPLE_W-1:0] kept_value_q, kept_value_d;
  logic                     out_valid_q, out_valid_d;
  logic                     rd_vld_q, rd_vld_d;

  // Working registers
  logic [SW-1:0]            newest_slot_q, newest_slot_d;
  logic [INDEX_W-1:0]       newest_idx_q, newest_idx_d;
  logic                     end_q, end_d;
  logic [RW-1:0]            r_q, r_d;
  logic [RW-1:0]            d_q, d_d;
  logic [DW-1:0]            k_q, k_d;
  logic [DW-1:0]            hi_q, hi_d;
  logic signed [SAMPLE_W-1:0] v_q, v_d;
  logic                     top_q, top_d, bot_q, bot_d;
  logic                     nlo_q, nlo_d, nhi_q, nhi_d;
  logic                     rd_v_q, rd_v_d;
  logic [DW-1:0]            rd_dist_q, rd_dist_d;
  logic [FX_W-1:0]          fx_q;
  logic [INDEX_W-1:0]       idx_q;
  logic signed [SAMPLE_W-1:0] echo_q;
  logic                     last_q;

  // Window RAM
  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic [SW-1:0]            raddr;
  logic                     mem_we;

  // Datapath helpers
  logic [RW-1:0]            r_eff;
  logic [INDEX_W-1:0]       new_count, nc_m1, lim;
  logic [DW-1:0]            sum_dr;
  logic [DW:0]              dp1, dm1;
  logic                     cand, w_gt, w_lt;
  fx_type_e                 cls, fx_new;
  logic                     keep, out_load, final_res;

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign fx_type_o      = fx_q;
  assign sample_index_o = idx_q;
  assign echo_value_o   = echo_q;
  assign last_of_run_o  = last_q;

  // Radius clamp to 1..MAX_RADIUS
  always_comb begin
    if (cfg_radius_q == '0) r_eff = RW'(1);
    else if (cfg_radius_q > RADIUS_CFG_W'(MAX_RADIUS)) r_eff = RW'(MAX_RADIUS);
    else r_eff = cfg_radius_q[RW-1:0];
  end

  // Counter and window bounds
  assign new_count = (count_q == '1) ? count_q : count_q + 1'b1;
  assign nc_m1     = new_count - 1'b1;
  assign lim       = count_q - 1'b1;
  assign sum_dr    = DW'(d_q) + DW'(r_q);
  assign dp1       = (DW+1)'(d_q) + 1'b1;
  assign dm1       = (DW+1)'(d_q) - 1'b1;
  assign cand      = (d_q != '0) && ((INDEX_W'(d_q) + 1'b1) < count_q);
  assign w_gt      = rdata_q > v_q;
  assign w_lt      = rdata_q < v_q;
  assign final_res = !end_q || (d_q == '0);

  // Candidate type and alternation filter
  always_comb begin
    cls = FX_NONE;
    if (cand && nlo_q && top_q) cls = FX_TOP;
    else if (cand && nhi_q && bot_q) cls = FX_BOTTOM;
    if (cls == FX_NONE) keep = 1'b0;
    else if (kept_type_q == FX_NONE) keep = 1'b1;
    else if (kept_type_q == cls) keep = 1'b0;
    else if (cls == FX_TOP) keep = v_q > kept_value_q;
    else keep = kept_value_q > v_q;
    fx_new = keep ? cls : FX_NONE;
  end

  // Sequencer: next state, read issue and window bookkeeping
  always_comb begin
    state_d       = state_q;
    wr_slot_d     = wr_slot_q;
    count_d       = count_q;
    kept_type_d   = kept_type_q;
    kept_value_d  = kept_value_q;
    newest_slot_d = newest_slot_q;
    newest_idx_d  = newest_idx_q;
    end_d         = end_q;
    r_d           = r_q;
    d_d           = d_q;
    k_d           = k_q;
    hi_d          = hi_q;
    v_d           = v_q;
    top_d         = top_q;
    bot_d         = bot_q;
    nlo_d         = nlo_q;
    nhi_d         = nhi_q;
    rd_vld_d      = 1'b0;
    rd_v_d        = 1'b0;
    rd_dist_d     = k_q;
    raddr         = slot_of(newest_slot_q, k_q);
    mem_we        = 1'b0;
    out_load      = 1'b0;

    // Consume the read issued last cycle
    if (rd_vld_q) begin
      if (rd_v_q) begin
        v_d = rdata_q;
      end else begin
        if (w_gt) top_d = 1'b0;
        if (w_lt) bot_d = 1'b0;
        if (cand && ({1'b0, rd_dist_q} == dp1 || {1'b0, rd_dist_q} == dm1)) begin
          nlo_d = nlo_q & w_lt;
          nhi_d = nhi_q & w_gt;
        end
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mem_we        = 1'b1;
          newest_slot_d = wr_slot_q;
          wr_slot_d     = (wr_slot_q == SW'(DEPTH - 1)) ? '0 : wr_slot_q + 1'b1;
          newest_idx_d  = count_q;
          count_d       = new_count;
          end_d         = end_of_series_i;
          r_d           = r_eff;
          if (end_of_series_i) begin
            d_d     = (INDEX_W'(r_eff) < nc_m1) ? r_eff : nc_m1[RW-1:0];
            state_d = ST_READV;
          end else begin
            d_d = r_eff;
            if (new_count > INDEX_W'(r_eff)) state_d = ST_READV;
          end
        end
      end
      ST_READV: begin
        raddr    = slot_of(newest_slot_q, DW'(d_q));
        rd_vld_d = 1'b1;
        rd_v_d   = 1'b1;
        hi_d     = (INDEX_W'(sum_dr) < lim) ? sum_dr : lim[DW-1:0];
        k_d      = '0;
        top_d    = 1'b1;
        bot_d    = 1'b1;
        nlo_d    = 1'b1;
        nhi_d    = 1'b1;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        rd_vld_d = 1'b1;
        if (k_q == hi_q) state_d = ST_TAIL;
        else k_d = k_q + 1'b1;
      end
      ST_TAIL: begin
        state_d = ST_FILT;
      end
      ST_FILT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (keep) begin
            kept_type_d  = cls;
            kept_value_d = v_q;
          end
          if (final_res) begin
            state_d = ST_IDLE;
            if (end_q) begin
              wr_slot_d    = '0;
              count_d      = '0;
              kept_type_d  = FX_NONE;
              kept_value_d = '0;
            end
          end else begin
            d_d     = d_q - 1'b1;
            state_d = ST_READV;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output beat holds until taken
  always_comb begin
    if (out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_radius_q <= RADIUS_CFG_W'(3);
      wr_slot_q    <= '0;
      count_q      <= '0;
      kept_type_q  <= FX_NONE;
      kept_value_q <= '0;
      out_valid_q  <= 1'b0;
      rd_vld_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) cfg_radius_q <= cfg_window_radius_i;
      wr_slot_q    <= wr_slot_d;
      count_q      <= count_d;
      kept_type_q  <= kept_type_d;
      kept_value_q <= kept_value_d;
      out_valid_q  <= out_valid_d;
      rd_vld_q     <= rd_vld_d;
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk_i) begin
    newest_slot_q <= newest_slot_d;
    newest_idx_q  <= newest_idx_d;
    end_q         <= end_d;
    r_q           <= r_d;
    d_q           <= d_d;
    k_q           <= k_d;
    hi_q          <= hi_d;
    v_q           <= v_d;
    top_q         <= top_d;
    bot_q         <= bot_d;
    nlo_q         <= nlo_d;
    nhi_q         <= nhi_d;
    rd_v_q        <= rd_v_d;
    rd_dist_q     <= rd_dist_d;
    if (out_load) begin
      fx_q   <= fx_new;
      idx_q  <= newest_idx_q - INDEX_W'(d_q);
      echo_q <= v_q;
      last_q <= final_res;
    end
  end

  // Window RAM: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_slot_q] <= sample_value_i;
    rdata_q <= mem[raddr];
  end

`ifndef SYNTH
  // Scan index never passes the window end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (k_q <= hi_q))
    else $error("window scan index beyond window end");

  // Window never reaches past the samples of this series
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (INDEX_W'(hi_q) < count_q))
    else $error("window read beyond stored series");

  // Final result of a series clears the series state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && end_q && d_q == '0) |=>
      (count_q == '0 && wr_slot_q == '0 && kept_type_q == FX_NONE))
    else $error("series state not cleared after end of series");
`endif

endmodule
